// File: rtl/dq_pkg.sv
// types and codes shared by the double-ended queue controller and datapath
// no dependencies
`default_nettype none

package dq_pkg;

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_BACK  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_BACK   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // operation the datapath carries out in its execute cycle
  typedef enum logic [2:0] {
    OP_NONE       = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4,
    OP_REJ_FULL   = 3'd5,
    OP_REJ_EMPTY  = 3'd6
  } op_e;

  typedef struct packed {
    logic load;  // capture item and read the ring store
    op_e  op;
  } cmd_t;

  typedef struct packed {
    action_e action;
    logic    full;
    logic    empty;
  } sts_t;

  localparam int unsigned DataW = 32;
  localparam int unsigned OccW  = 5;

endpackage

`default_nettype wire

// File: rtl/double_ended_queue_top.sv
// top level of the double-ended queue: controller plus ring-store datapath
// depends on dq_pkg, dq_ctrl, dq_datapath
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------------
//   input    | in_valid_i / in_stall_o    | action_i[1:0], value_i[31:0]
//   output   | out_valid_o / out_stall_i  | data_o[31:0], status_o[1:0],
//            |                            | occupancy_o[4:0]
//
// the accept cycle reads the ring store into a register, the next cycle
// updates pointers, writes a push and loads the result
// the single ring-store port with its registered read sets this split
// reset clears the front pointer, the count and the control; the store is not cleared
// a stalled result holds; a new item is taken once the result register drains
`default_nettype none

module double_ended_queue_top #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         action_i,
  input  wire logic signed [31:0] value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      data_o,
  output logic [1:0]              status_o,
  output logic [4:0]              occupancy_o
);

  dq_pkg::cmd_t cmd;
  dq_pkg::sts_t sts;

  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .action_i    (action_i),
    .value_i     (value_i),
    .data_o      (data_o),
    .status_o    (status_o),
    .occupancy_o (occupancy_o)
  );

endmodule

`default_nettype wire

// File: rtl/dq_datapath.sv
// ring store, front pointer, entry count, item and result registers
// depends on dq_pkg
`default_nettype none

module dq_datapath #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire dq_pkg::cmd_t                   cmd_i,
  output dq_pkg::sts_t                        sts_o,
  input  wire logic [1:0]                     action_i,
  input  wire logic signed [dq_pkg::DataW-1:0] value_i,
  output logic signed [dq_pkg::DataW-1:0]     data_o,
  output logic [1:0]                          status_o,
  output logic [dq_pkg::OccW-1:0]             occupancy_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam logic [SW-1:0] DepthS = SW'(DEPTH);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

  logic [dq_pkg::DataW-1:0] mem [DEPTH];

  logic [AW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;
  dq_pkg::action_e action_q;
  logic signed [dq_pkg::DataW-1:0] value_q;
  logic [dq_pkg::DataW-1:0] rdata_q;
  logic signed [dq_pkg::DataW-1:0] data_q, data_d;
  dq_pkg::status_e status_q, status_d;
  logic [dq_pkg::OccW-1:0] occ_q;

  logic [SW-1:0] back_sum, tail_sum;
  logic [AW-1:0] back_ptr, tail_ptr, front_inc, front_dec, raddr, waddr;
  logic          we;

  // back entry sits at front + count - 1, tail slot at front + count, both mod depth
  always_comb begin
    back_sum = SW'(front_q) + SW'(count_q) - SW'(1);
    tail_sum = SW'(front_q) + SW'(count_q);
    if (count_q == '0) begin
      back_ptr = front_q;
    end else if (back_sum >= DepthS) begin
      back_ptr = AW'(back_sum - DepthS);
    end else begin
      back_ptr = AW'(back_sum);
    end
    if (tail_sum >= DepthS) begin
      tail_ptr = AW'(tail_sum - DepthS);
    end else begin
      tail_ptr = AW'(tail_sum);
    end
    front_inc = (front_q == LastIdx) ? '0 : front_q + AW'(1);
    front_dec = (front_q == '0) ? LastIdx : front_q - AW'(1);
    raddr = (dq_pkg::action_e'(action_i) == dq_pkg::ACT_POP_FRONT) ? front_q : back_ptr;
  end

  assign sts_o.action = action_q;
  assign sts_o.full   = (count_q == DepthC);
  assign sts_o.empty  = (count_q == '0);

  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    data_d   = '0;
    status_d = dq_pkg::ST_OK;
    we       = 1'b0;
    waddr    = tail_ptr;
    unique case (cmd_i.op)
      dq_pkg::OP_PUSH_FRONT: begin
        front_d = front_dec;
        waddr   = front_dec;
        we      = 1'b1;
        count_d = count_q + CW'(1);
      end
      dq_pkg::OP_PUSH_BACK: begin
        we      = 1'b1;
        count_d = count_q + CW'(1);
      end
      dq_pkg::OP_POP_FRONT: begin
        data_d  = $signed(rdata_q);
        front_d = front_inc;
        count_d = count_q - CW'(1);
      end
      dq_pkg::OP_POP_BACK: begin
        data_d  = $signed(rdata_q);
        count_d = count_q - CW'(1);
      end
      dq_pkg::OP_REJ_FULL:  status_d = dq_pkg::ST_FULL;
      dq_pkg::OP_REJ_EMPTY: status_d = dq_pkg::ST_EMPTY;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= dq_pkg::action_e'(action_i);
      value_q  <= value_i;
    end
    if (cmd_i.op != dq_pkg::OP_NONE) begin
      data_q   <= data_d;
      status_q <= status_d;
      occ_q    <= dq_pkg::OccW'(count_d);
    end
  end

  // ring store: one read on item capture, one write on a push in the execute cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rdata_q <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= value_q;
    end
  end

  assign data_o      = data_q;
  assign status_o    = status_q;
  assign occupancy_o = occ_q;

endmodule

`default_nettype wire

// File: rtl/dq_ctrl.sv
// handshake controller: accepts items, picks the operation, holds result valid
// depends on dq_pkg
`default_nettype none

module dq_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output dq_pkg::cmd_t      cmd_o,
  input  wire dq_pkg::sts_t sts_i
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_acc;

  // take a new item only in idle and when the result register is free or drains now
  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.op   = dq_pkg::OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        unique case (sts_i.action)
          dq_pkg::ACT_PUSH_FRONT:
            cmd_o.op = sts_i.full ? dq_pkg::OP_REJ_FULL : dq_pkg::OP_PUSH_FRONT;
          dq_pkg::ACT_PUSH_BACK:
            cmd_o.op = sts_i.full ? dq_pkg::OP_REJ_FULL : dq_pkg::OP_PUSH_BACK;
          dq_pkg::ACT_POP_FRONT:
            cmd_o.op = sts_i.empty ? dq_pkg::OP_REJ_EMPTY : dq_pkg::OP_POP_FRONT;
          dq_pkg::ACT_POP_BACK:
            cmd_o.op = sts_i.empty ? dq_pkg::OP_REJ_EMPTY : dq_pkg::OP_POP_BACK;
          default: cmd_o.op = dq_pkg::OP_NONE;
        endcase
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (state_q == S_EXEC) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: dv/tb_double_ended_queue_top.sv
`timescale 1ns / 1ps
// testbench for double_ended_queue_top: directed rows, then biased random push/pop traffic
// results are checked field by field against a directed row's reply or a ring-store deque predictor
// depends on dq_pkg and the double_ended_queue_top rtl

module tb_double_ended_queue_top;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned RANDOM_OPS = 1430;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    logic signed [31:0] data;
    dq_pkg::status_e    status;
    logic [4:0]         occupancy;
  } deque_reply_t;

  typedef struct packed {
    dq_pkg::action_e act;
    logic [31:0]     value;
    logic [4:0]      reps;
    logic            known;
    deque_reply_t    reply;
  } directed_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         action_i = dq_pkg::ACT_PUSH_FRONT;
  logic signed [31:0] value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] data_o;
  logic [1:0]         status_o;
  logic [4:0]         occupancy_o;

  // predictor state
  logic signed [31:0] ring_store [DEPTH];
  int unsigned        ring_front;
  int unsigned        ring_count;

  deque_reply_t deque_replies_q [$];
  int           mismatch_count;
  int unsigned  send_idle_pct = 31;
  int unsigned  recv_stall_pct = 31;
  bit           hold_req;
  int unsigned  quiet_cycles;

  // values that count up from -8 run through -1 and 0
  directed_row_t directed_rows [0:9] = '{
    '{dq_pkg::ACT_POP_FRONT,  32'h0000_0000, 5'd1,  1'b1, '{32'sh0, dq_pkg::ST_EMPTY, 5'd0}},
    '{dq_pkg::ACT_POP_BACK,   32'hffff_ffff, 5'd1,  1'b1, '{32'sh0, dq_pkg::ST_EMPTY, 5'd0}},
    '{dq_pkg::ACT_PUSH_FRONT, 32'h7fff_ffff, 5'd1,  1'b1, '{32'sh0, dq_pkg::ST_OK, 5'd1}},
    '{dq_pkg::ACT_PUSH_BACK,  32'h8000_0000, 5'd1,  1'b1, '{32'sh0, dq_pkg::ST_OK, 5'd2}},
    '{dq_pkg::ACT_PUSH_BACK,  32'hffff_fff8, 5'd14, 1'b0, '{32'sh0, dq_pkg::ST_OK, 5'd0}},
    '{dq_pkg::ACT_PUSH_FRONT, 32'h1234_5678, 5'd1,  1'b1, '{32'sh0, dq_pkg::ST_FULL, 5'd16}},
    '{dq_pkg::ACT_PUSH_BACK,  32'ha5a5_a5a5, 5'd1,  1'b1, '{32'sh0, dq_pkg::ST_FULL, 5'd16}},
    '{dq_pkg::ACT_POP_FRONT,  32'hffff_ffff, 5'd1,  1'b1,
      '{32'sh7fff_ffff, dq_pkg::ST_OK, 5'd15}},
    '{dq_pkg::ACT_POP_BACK,   32'h0000_0001, 5'd1,  1'b0, '{32'sh0, dq_pkg::ST_OK, 5'd0}},
    '{dq_pkg::ACT_POP_FRONT,  32'h0000_0000, 5'd1,  1'b1,
      '{32'sh8000_0000, dq_pkg::ST_OK, 5'd13}}
  };

  double_ended_queue_top #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .data_o     (data_o),
    .status_o   (status_o),
    .occupancy_o(occupancy_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic deque_reply_t apply_deque_op(dq_pkg::action_e act,
                                                  logic signed [31:0] val);
    deque_reply_t r;
    r.data = '0;
    r.status = dq_pkg::ST_OK;
    if (act == dq_pkg::ACT_PUSH_FRONT || act == dq_pkg::ACT_PUSH_BACK) begin
      if (ring_count >= DEPTH) begin
        r.status = dq_pkg::ST_FULL;
      end else if (act == dq_pkg::ACT_PUSH_FRONT) begin
        ring_front = (ring_front + DEPTH - 1) % DEPTH;
        ring_store[ring_front] = val;
        ring_count++;
      end else begin
        ring_store[(ring_front + ring_count) % DEPTH] = val;
        ring_count++;
      end
    end else begin
      if (ring_count == 0) begin
        r.status = dq_pkg::ST_EMPTY;
      end else if (act == dq_pkg::ACT_POP_FRONT) begin
        r.data = ring_store[ring_front];
        ring_front = (ring_front + 1) % DEPTH;
        ring_count--;
      end else begin
        r.data = ring_store[(ring_front + ring_count - 1) % DEPTH];
        ring_count--;
      end
    end
    r.occupancy = 5'(ring_count);
    return r;
  endfunction

  // offer one item, hold it until taken, then record what it should return
  task automatic issue_op(dq_pkg::action_e act, logic [31:0] val, bit known,
                          deque_reply_t reply);
    deque_reply_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    value_i <= val;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predicted = apply_deque_op(act, val);
    deque_replies_q.push_back(known ? reply : predicted);
  endtask

  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (deque_replies_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    deque_reply_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (deque_replies_q.size() == 0) begin
        $error("result with no item pending: data %0d status %0d occupancy %0d",
               data_o, status_o, occupancy_o);
        mismatch_count++;
      end else begin
        want = deque_replies_q.pop_front();
        if (data_o !== want.data) begin
          $error("data mismatch: expected %0d, got %0d", want.data, data_o);
          mismatch_count++;
        end
        if (status_o !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, status_o);
          mismatch_count++;
        end
        if (occupancy_o !== want.occupancy) begin
          $error("occupancy mismatch: expected %0d, got %0d", want.occupancy, occupancy_o);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("double_ended_queue_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    directed_row_t   row;
    deque_reply_t    none;
    int unsigned     push_pct;
    dq_pkg::action_e act;
    logic [31:0]     val;
    none = '0;
    push_pct = 50;
    ring_front = 0;
    ring_count = 0;
    mismatch_count = 0;
    quiet_cycles = 0;
    hold_req = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      for (int r = 0; r < row.reps; r++) begin
        issue_op(row.act, row.value + 32'(r), row.known, row.reply);
      end
    end
    wait_all_results();

    for (int n = 0; n < RANDOM_OPS; n++) begin
      // bias swings between filling and draining so both ends get hit
      if (n % 60 == 0) begin
        case ($urandom_range(0, 4))
          0: push_pct = 10;
          1: push_pct = 35;
          2: push_pct = 50;
          3: push_pct = 65;
          default: push_pct = 90;
        endcase
      end
      if (n == 200) hold_req = 1'b1;
      if (n == 400 || n == 900) wait_all_results();
      if (n == 600) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      if (n == 800) begin
        send_idle_pct = 31;
        recv_stall_pct = 31;
      end
      if ($urandom_range(0, 99) < push_pct) begin
        act = $urandom_range(0, 1) ? dq_pkg::ACT_PUSH_BACK : dq_pkg::ACT_PUSH_FRONT;
      end else begin
        act = $urandom_range(0, 1) ? dq_pkg::ACT_POP_BACK : dq_pkg::ACT_POP_FRONT;
      end
      if ($urandom_range(0, 15) == 0) begin
        case ($urandom_range(0, 3))
          0: val = 32'h7fff_ffff;
          1: val = 32'h8000_0000;
          2: val = 32'h0000_0000;
          default: val = 32'hffff_ffff;
        endcase
      end else begin
        val = $urandom;
      end
      issue_op(act, val, 1'b0, none);
    end
    wait_all_results();

    if (mismatch_count == 0) begin
      $display("double_ended_queue_top test passed");
    end else begin
      $display("double_ended_queue_top test failed");
    end
    $finish;
  end

endmodule
